// ===== rtl/core/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants of the move-towards-target limiter.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SPEED_W = 31;
  localparam int DT_W    = 16;
  localparam int VAL_W   = 32;
  localparam int DIFF_W  = 33;
  localparam int SQ_W    = 66;
  localparam int ROOT_W  = 33;
  localparam int STEP_W  = 31;
  localparam int PROD_W  = 64;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    REG_MOVE   = 2'd0,
    REG_SCALE  = 2'd1,
    REG_ROTATE = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_ROOT,
    ST_CHECK,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_ROT,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       pair_sel;
    logic       sq;
    logic       root_start;
    logic       root_step;
    logic       check;
    logic       mul_sel_y;
    logic       mul;
    logic       div_start;
    logic       div_step;
    logic       upd_x;
    logic       upd_y;
    logic       rot;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic snap;
    logic iter_done;
  } status_t;

endpackage

// ===== rtl/core/mtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer for one tick: two pair updates, then the rotation.
// ----------------------------------------------------------------------------
module mtt_ctrl
  import mtt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    out_free,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;
  logic   pair, pair_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pair  <= 1'b0;
    end else begin
      state <= state_next;
      pair  <= pair_next;
    end
  end

  always_comb begin
    state_next = state;
    pair_next  = pair;
    case (state)
      ST_IDLE: if (in_fire) begin
        state_next = ST_LOAD;
        pair_next  = 1'b0;
      end
      ST_LOAD:  state_next = ST_SQ;
      ST_SQ:    state_next = ST_ROOT;
      ST_ROOT:  if (sts.iter_done) state_next = ST_CHECK;
      ST_CHECK: state_next = (sts.skip || sts.snap) ? ST_NEXT : ST_MULX;
      ST_MULX:  state_next = ST_DIVX;
      ST_DIVX:  if (sts.iter_done) state_next = ST_MULY;
      ST_MULY:  state_next = ST_DIVY;
      ST_DIVY:  if (sts.iter_done) state_next = ST_NEXT;
      ST_NEXT: begin
        if (pair) begin
          state_next = ST_ROT;
        end else begin
          pair_next  = 1'b1;
          state_next = ST_SQ;
        end
      end
      ST_ROT:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.pair_sel = pair;
    busy         = (state != ST_IDLE);
    case (state)
      ST_LOAD:  cmd.load = 1'b1;
      ST_SQ: begin
        cmd.sq         = 1'b1;
        cmd.root_start = 1'b1;
      end
      ST_ROOT:  cmd.root_step = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_MULX: begin
        cmd.mul       = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIVX: begin
        cmd.div_step = 1'b1;
        cmd.upd_x    = sts.iter_done;
      end
      ST_MULY: begin
        cmd.mul       = 1'b1;
        cmd.mul_sel_y = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIVY: begin
        cmd.div_step = 1'b1;
        cmd.upd_y    = sts.iter_done;
      end
      ST_ROT:   cmd.rot = 1'b1;
      ST_OUT:   cmd.out_load = out_free;
      default:  ;
    endcase
  end

endmodule

// ===== rtl/core/mtt_dp.sv =====
// ----------------------------------------------------------------------------
// mtt_dp
// Datapath: state registers, squarer, bit-serial root, restoring divider.
// ----------------------------------------------------------------------------
module mtt_dp
  import mtt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic                 in_fire,
  input  logic [DT_W-1:0]      delta_time,
  input  logic signed [VAL_W-1:0] goal_x,
  input  logic signed [VAL_W-1:0] goal_y,
  input  logic signed [VAL_W-1:0] goal_scale_x,
  input  logic signed [VAL_W-1:0] goal_scale_y,
  input  logic signed [VAL_W-1:0] goal_angle,
  input  logic [SPEED_W-1:0]   move_speed,
  input  logic [SPEED_W-1:0]   scale_speed,
  input  logic [SPEED_W-1:0]   rotate_speed,
  output logic signed [VAL_W-1:0] cur_x,
  output logic signed [VAL_W-1:0] cur_y,
  output logic signed [VAL_W-1:0] cur_sx,
  output logic signed [VAL_W-1:0] cur_sy,
  output logic signed [VAL_W-1:0] cur_ang
);

  localparam longint OneQ    = longint'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0] DeadLin = ROOT_W'((OneQ + 500) / 1000);
  localparam logic [ROOT_W-1:0] DeadRot = ROOT_W'((OneQ + 50) / 100);
  localparam logic signed [VAL_W-1:0] OneVal = VAL_W'(OneQ);

  logic [DT_W-1:0]         dt;
  logic signed [VAL_W-1:0] gx, gy, gsx, gsy, ga;
  logic [STEP_W-1:0]       step;
  logic [STEP_W+DT_W-1:0]  sp_prod;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-2:0]       mx, my;
  logic [SQ_W-1:0]         rem_sq;
  logic [ROOT_W-1:0]       root;
  logic [CNT_W-1:0]        cnt;
  logic [PROD_W-1:0]       num;
  logic [ROOT_W:0]         drem;
  logic [PROD_W-1:0]       quo;
  logic                    snap_c, skip_c;

  logic signed [VAL_W-1:0] sel_cx, sel_cy, sel_gx, sel_gy;
  logic [SPEED_W-1:0]      sel_spd;
  logic [DIFF_W-1:0]       dxc, dyc;
  logic [DIFF_W-2:0]       mxc, myc;

  assign sel_cx  = cmd.pair_sel ? cur_sx : cur_x;
  assign sel_cy  = cmd.pair_sel ? cur_sy : cur_y;
  assign sel_gx  = cmd.pair_sel ? gsx : gx;
  assign sel_gy  = cmd.pair_sel ? gsy : gy;
  assign sel_spd = cmd.pair_sel ? scale_speed : move_speed;
  assign dxc = DIFF_W'(sel_gx) - DIFF_W'(sel_cx);
  assign dyc = DIFF_W'(sel_gy) - DIFF_W'(sel_cy);
  assign mxc = dxc[DIFF_W-1] ? (DIFF_W-1)'(-dxc) : dxc[DIFF_W-2:0];
  assign myc = dyc[DIFF_W-1] ? (DIFF_W-1)'(-dyc) : dyc[DIFF_W-2:0];
  assign sp_prod = sel_spd * dt;

  // root trial: (2r + bit) * bit over shifted remainder, one bit per cycle
  logic [CNT_W-1:0]  bitpos;
  logic [ROOT_W-1:0] trial_r;
  logic [SQ_W+1:0]   trial_sq;
  assign bitpos   = cnt;
  assign trial_r  = root | (ROOT_W'(1) << bitpos[5:0]);
  assign trial_sq = ((SQ_W+2)'(root) << (bitpos[5:0] + 6'd1))
                  + ((SQ_W+2)'(1) << {bitpos[5:0], 1'b0});

  logic [ROOT_W:0] dsh;
  assign dsh = {drem[ROOT_W-1:0], num[PROD_W-1]};

  logic signed [DIFF_W-1:0] ad;
  logic [ROOT_W-1:0]        rot_m;
  logic [STEP_W-1:0]        rot_step;
  logic [STEP_W+DT_W-1:0]   rot_prod;
  assign ad = DIFF_W'(ga) - DIFF_W'(cur_ang);
  assign rot_m = ad[DIFF_W-1] ? ROOT_W'(-ad) : ROOT_W'(ad);
  assign rot_prod = rotate_speed * dt;
  assign rot_step = rot_prod[DT_W +: STEP_W];

  assign skip_c = (root <= DeadLin) || (root == '0);
  assign snap_c = (ROOT_W'(step) >= root);

  assign sts.skip = skip_c;
  assign sts.snap = snap_c;
  assign sts.iter_done = (cnt == '0);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dt  <= delta_time;
      gx  <= goal_x;
      gy  <= goal_y;
      gsx <= goal_scale_x;
      gsy <= goal_scale_y;
      ga  <= goal_angle;
    end
    if (cmd.sq) begin
      dx     <= dxc;
      dy     <= dyc;
      mx     <= mxc;
      my     <= myc;
      rem_sq <= SQ_W'(PROD_W'(mxc) * PROD_W'(mxc)) + SQ_W'(PROD_W'(myc) * PROD_W'(myc));
      root   <= '0;
      step   <= sp_prod[DT_W +: STEP_W];
    end
    if (cmd.root_start) cnt <= CNT_W'(ROOT_W - 1);
    if (cmd.root_step) begin
      if ((SQ_W+2)'(rem_sq) >= trial_sq) begin
        rem_sq <= rem_sq - SQ_W'(trial_sq);
        root   <= trial_r;
      end
      if (cnt != '0) cnt <= cnt - 1'b1;
    end
    if (cmd.mul) begin
      num  <= PROD_W'(cmd.mul_sel_y ? my : mx) * PROD_W'(step);
      drem <= '0;
      quo  <= '0;
      cnt  <= CNT_W'(PROD_W - 1);
    end
    if (cmd.div_step) begin
      num <= num << 1;
      if (dsh >= {1'b0, root}) begin
        drem <= dsh - {1'b0, root};
        quo  <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        drem <= dsh;
        quo  <= {quo[PROD_W-2:0], 1'b0};
      end
      if (cnt != '0) cnt <= cnt - 1'b1;
    end
  end

  // final quotient bit, available in the last divide cycle
  logic [PROD_W-1:0]      qfin;
  logic signed [VAL_W-1:0] nx, ny;
  assign qfin = {quo[PROD_W-2:0], (dsh >= {1'b0, root})};
  assign nx = dx[DIFF_W-1] ? sel_cx - VAL_W'(qfin) : sel_cx + VAL_W'(qfin);
  assign ny = dy[DIFF_W-1] ? sel_cy - VAL_W'(qfin) : sel_cy + VAL_W'(qfin);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x   <= '0;
      cur_y   <= '0;
      cur_sx  <= OneVal;
      cur_sy  <= OneVal;
      cur_ang <= '0;
    end else begin
      if (cmd.check && !skip_c && snap_c) begin
        if (cmd.pair_sel) begin
          cur_sx <= gsx;
          cur_sy <= gsy;
        end else begin
          cur_x <= gx;
          cur_y <= gy;
        end
      end
      if (cmd.upd_x) begin
        if (cmd.pair_sel) cur_sx <= nx;
        else cur_x <= nx;
      end
      if (cmd.upd_y) begin
        if (cmd.pair_sel) cur_sy <= ny;
        else cur_y <= ny;
      end
      if (cmd.rot && rot_m > DeadRot) begin
        if (ROOT_W'(rot_step) >= rot_m) cur_ang <= ga;
        else if (ad[DIFF_W-1]) cur_ang <= cur_ang - VAL_W'(rot_step);
        else cur_ang <= cur_ang + VAL_W'(rot_step);
      end
    end
  end

endmodule

// ===== rtl/core/move_towards_target_limiter_top.sv =====
// ----------------------------------------------------------------------------
// move_towards_target_limiter_top
// Constant-speed approach of position, scale and rotation toward targets.
// ----------------------------------------------------------------------------
// One input beat is one tick and gives one output beat. Per coordinate pair
// the datapath runs a bit-serial square root and, for a partial move, two
// restoring divisions (one per axis); the same hardware serves both pairs,
// then the rotation step follows. A pair that holds or snaps skips both
// divisions. The next beat is taken once the result sits in the output
// register, while it waits for tready.
module move_towards_target_limiter_top
  import mtt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // delta_time[15:0], goal_x[47:16], goal_y[79:48], goal_scale_x[111:80],
  // goal_scale_y[143:112], goal_angle[175:144]
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], size_x[95:64], size_y[127:96], angle[159:128]
  output logic [159:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [SPEED_W-1:0] move_speed, scale_speed, rotate_speed;
  cmd_t    cmd;
  status_t sts;
  logic    busy, in_fire, out_free;
  logic signed [VAL_W-1:0] cx, cy, csx, csy, ca;
  reg_idx_t widx;

  assign pready  = 1'b1;
  assign widx    = reg_idx_t'(paddr[3:2]);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed   <= '0;
      scale_speed  <= '0;
      rotate_speed <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_MOVE:   move_speed   <= pwdata[SPEED_W-1:0];
        REG_SCALE:  scale_speed  <= pwdata[SPEED_W-1:0];
        REG_ROTATE: rotate_speed <= pwdata[SPEED_W-1:0];
        default:    move_speed   <= move_speed;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (widx)
      REG_MOVE:   prdata = {1'b0, move_speed};
      REG_SCALE:  prdata = {1'b0, scale_speed};
      REG_ROTATE: prdata = {1'b0, rotate_speed};
      default:    prdata = '0;
    endcase
  end

  mtt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  mtt_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_fire(in_fire),
    .delta_time(s_axis_tdata[15:0]),
    .goal_x(s_axis_tdata[47:16]),
    .goal_y(s_axis_tdata[79:48]),
    .goal_scale_x(s_axis_tdata[111:80]),
    .goal_scale_y(s_axis_tdata[143:112]),
    .goal_angle(s_axis_tdata[175:144]),
    .move_speed(move_speed), .scale_speed(scale_speed),
    .rotate_speed(rotate_speed),
    .cur_x(cx), .cur_y(cy), .cur_sx(csx), .cur_sy(csy), .cur_ang(ca)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_axis_tdata <= {ca, csy, csx, cy, cx};
  end

endmodule

// ===== rtl/core/mtt_checker.sv =====
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks of the limiter's stream behavior.
// ----------------------------------------------------------------------------
module mtt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic         pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("beat accepted while busy");

  a_noout: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind move_towards_target_limiter_top mtt_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

// ===== tb/tb_move_towards_target_limiter_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_move_towards_target_limiter_top
// Tick-by-tick check of the move-towards-target limiter.
// A directed table of ticks, then random ticks, driven over the input
// stream, mostly with random gaps. Every output beat is compared to a local
// predictor of position, scale and rotation. Speed registers are set over
// APB only while the block is idle, several settings including extremes.
// ----------------------------------------------------------------------------
module tb_move_towards_target_limiter_top;
  import mtt_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned ONE_Q = 64'd1 << FB;
  localparam longint unsigned DEAD_LIN = (ONE_Q + 500) / 1000;
  localparam longint unsigned DEAD_ROT = (ONE_Q + 50) / 100;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 450;

  typedef struct packed {
    logic [31:0] ang, gsy, gsx, gy, gx;
    logic [15:0] dt;
  } tick_t;

  typedef struct packed {
    logic [31:0] ang, sy, sx, y, x;
  } pose_t;

  typedef struct {
    tick_t t;
    logic  has_pose;
    pose_t pose;
  } row_t;

  logic         clk = 0, rst = 1;
  logic         s_axis_tvalid = 0, m_axis_tready = 0;
  logic [175:0] s_axis_tdata = '0;
  logic         s_axis_tready, m_axis_tvalid;
  logic [159:0] m_axis_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  move_towards_target_limiter_top uut (.*);

  initial forever #4 clk = ~clk;

  // predictor state
  longint unsigned spd_move, spd_scale, spd_rot;
  longint px, py, psx, psy, pang;
  pose_t pose_q[$];
  int errors = 0, beats_out = 0, beats_in = 0, idle_cycles = 0;
  bit gaps_on = 1;

  function automatic longint unsigned mag(longint d);
    return d < 0 ? longint'(-d) : longint'(d);
  endfunction

  function automatic longint unsigned isqrt66(logic [65:0] v);
    logic [65:0] r, c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (66'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic void move_pair(inout longint cx, inout longint cy, input longint gx,
                                    input longint gy, input longint unsigned spd,
                                    input longint unsigned dt);
    longint dx, dy;
    logic [65:0] sq;
    longint unsigned span, stp;
    logic [127:0] m;
    dx = gx - cx;
    dy = gy - cy;
    sq = 66'(mag(dx)) * 66'(mag(dx)) + 66'(mag(dy)) * 66'(mag(dy));
    span = isqrt66(sq);
    if (span <= DEAD_LIN || span == 0) return;
    stp = (spd * dt) >> 16;
    if (stp >= span) begin
      cx = gx;
      cy = gy;
    end else begin
      m = (128'(mag(dx)) * stp) / span;
      cx = dx < 0 ? cx - longint'(m) : cx + longint'(m);
      m = (128'(mag(dy)) * stp) / span;
      cy = dy < 0 ? cy - longint'(m) : cy + longint'(m);
    end
  endfunction

  function automatic pose_t advance_pose(tick_t t);
    pose_t p;
    longint r;
    longint unsigned stp;
    move_pair(px, py, longint'($signed(t.gx)), longint'($signed(t.gy)), spd_move, t.dt);
    move_pair(psx, psy, longint'($signed(t.gsx)), longint'($signed(t.gsy)), spd_scale,
              t.dt);
    r = longint'($signed(t.ang)) - pang;
    if (mag(r) > DEAD_ROT) begin
      stp = (spd_rot * t.dt) >> 16;
      if (stp >= mag(r)) pang = longint'($signed(t.ang));
      else if (r > 0) pang += stp;
      else pang -= stp;
    end
    p.x = px[31:0]; p.y = py[31:0]; p.sx = psx[31:0]; p.sy = psy[31:0];
    p.ang = pang[31:0];
    return p;
  endfunction

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_MOVE:   spd_move = val[30:0];
      REG_SCALE:  spd_scale = val[30:0];
      REG_ROTATE: spd_rot = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_speeds(logic [31:0] m, logic [31:0] s, logic [31:0] r);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    apb_write(REG_MOVE, m);
    apb_write(REG_SCALE, s);
    apb_write(REG_ROTATE, r);
  endtask

  task automatic send_tick(tick_t t, logic has_pose, pose_t want);
    pose_t p;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 25) @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    p = advance_pose(t);
    if (has_pose && p != want) begin
      errors++;
      $display("table row disagrees with predictor: %h vs %h", want, p);
    end
    pose_q.push_back(p);
    beats_in++;
    @(negedge clk);
    s_axis_tvalid <= 0;
  endtask

  // output side
  always @(negedge clk) m_axis_tready <= rst ? 1'b0 : (!gaps_on || $urandom_range(99) >= 25);

  always @(posedge clk) begin
    pose_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (pose_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat %h", m_axis_tdata);
      end else begin
        w = pose_q.pop_front();
        if (m_axis_tdata != w) begin
          errors++;
          if (errors <= 10)
            $display("pose mismatch: exp x=%h y=%h sx=%h sy=%h a=%h got x=%h y=%h sx=%h sy=%h a=%h",
                     w.x, w.y, w.sx, w.sy, w.ang, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tdata[159:128]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d beats outstanding", pose_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic tick_t mk(logic [15:0] dt, logic [31:0] gx, logic [31:0] gy,
                               logic [31:0] gsx, logic [31:0] gsy, logic [31:0] ga);
    tick_t t;
    t.dt = dt; t.gx = gx; t.gy = gy; t.gsx = gsx; t.gsy = gsy; t.ang = ga;
    return t;
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    return base + 32'($signed($urandom_range(8192)) - 4096) * (1 << $urandom_range(8));
  endfunction

  initial begin
    row_t table_rows[$];
    row_t row;
    tick_t t;
    pose_t none;
    logic [31:0] gx, gy, gsx, gsy, ga;
    none = '0;
    spd_move = 0; spd_scale = 0; spd_rot = 0;
    px = 0; py = 0; psx = ONE_Q; psy = ONE_Q; pang = 0;

    // zero speeds after reset: pose holds
    row.t = mk(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
               32'h7FFFFFFF);
    row.has_pose = 1;
    row.pose = '{ang: 0, sy: 32'h10000, sx: 32'h10000, y: 0, x: 0};
    table_rows.push_back(row);
    row.has_pose = 0;
    row.t = mk(0, 1, 1, 1, 1, 1); table_rows.push_back(row);

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;

    foreach (table_rows[i]) send_tick(table_rows[i].t, table_rows[i].has_pose,
                                      table_rows[i].pose);

    // max speeds: long moves toward the extremes
    set_speeds(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    table_rows.delete();
    row.has_pose = 0;
    row.pose = none;
    row.t = mk(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000);
    table_rows.push_back(row);
    row.t = mk(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF);
    table_rows.push_back(row);
    // dead-band sized offsets
    row.t = mk(16'hFFFF, 32'h80000000 + 32'(DEAD_LIN), 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h80000000 + 32'(DEAD_LIN + 1), 32'h7FFFFFFF - 32'(DEAD_ROT));
    table_rows.push_back(row);
    row.t = mk(1, 0, 0, 32'h10000, 32'h10000, 32'h7FFFFFFF - 32'(DEAD_ROT + 1));
    table_rows.push_back(row);
    row.t = mk(0, 5, 5, 5, 5, 0); table_rows.push_back(row);
    foreach (table_rows[i]) send_tick(table_rows[i].t, table_rows[i].has_pose,
                                      table_rows[i].pose);

    // slow speeds: partial moves toward targets
    set_speeds(32'h0001_8000, 32'h0000_4000, 32'h0005_0000);
    table_rows.delete();
    row.has_pose = 0;
    row.t = mk(16'h8000, 32'h0003_0000, 32'h0004_0000, 32'h0002_0000, 32'hFFFF_0000,
               32'h005A_0000);
    repeat (4) table_rows.push_back(row);
    row.t = mk(16'hFFFF, 32'hFFFD_0000, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000,
               32'hFFA6_0000);
    repeat (4) table_rows.push_back(row);
    row.t = mk(16'h0001, 32'h0000_0042, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 0);
    table_rows.push_back(row);
    foreach (table_rows[i]) send_tick(table_rows[i].t, table_rows[i].has_pose,
                                      table_rows[i].pose);

    // random phases with new speeds each phase
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_speeds(0, 0, 0);
        1: set_speeds(32'h7FFFFFFF, 1, 32'h0000_0100);
        default: set_speeds($urandom_range(32'h0010_0000) << $urandom_range(10),
                            $urandom_range(32'h0004_0000), $urandom());
      endcase
      gaps_on = (ph != 3);
      gx = $urandom(); gy = $urandom(); gsx = $urandom_range(32'h4_0000);
      gsy = $urandom(); ga = $urandom();
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        if ($urandom_range(9) < 2) begin
          gx = $urandom(); gy = $urandom(); gsx = $urandom(); gsy = $urandom();
          ga = $urandom();
        end else if ($urandom_range(9) < 3) begin
          gx = near(px[31:0]); gy = near(py[31:0]); gsx = near(psx[31:0]);
          gsy = near(psy[31:0]); ga = near(pang[31:0]);
        end
        t = mk(16'($urandom()), gx, gy, gsx, gsy, ga);
        send_tick(t, 0, none);
      end
    end
    gaps_on = 1;

    while (pose_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d ticks in, %0d poses out over directed and six random speed phases",
             beats_in, beats_out);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
